/* hdl/steq_pkg.sv */
package steq_pkg;

   localparam logic [1:0] REQ_SET    = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EVICT   = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   localparam logic [5:0] NIL = 6'd63;

   typedef struct packed {
      logic [7:0]  ev_class;
      logic [7:0]  ev_code;
      logic [15:0] ev_data;
   } event_type;

   typedef struct packed {
      logic        res_kind;
      logic [7:0]  out_class;
      logic [7:0]  out_code;
      logic [15:0] out_data;
      logic [1:0]  status;
      logic        last;
   } result_type;

endpackage

/* hdl/sorted_timer_event_queue.sv */
// sorted timer event queue, list kept in one slot memory and one link memory
// set reads the evicted head (when no slot is free) and the free slot, then walks the list
// entry by entry; cancel walks it too, with a relink step where an entry is unlinked behind
// a kept one; a tick adds a wrap pass over the list when time has wrapped, then posts due events
// one request is taken at a time, only in idle; posting waits while the receiver stalls
// synchronous active-high reset, then a clearing pass over every slot with no request taken
module sorted_timer_event_queue import steq_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: now[30:0], delay[46:31], ev_class[54:47], ev_code[62:55],
   // ev_data[78:63], zero fill to 80
   input  logic [79:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: out_class[7:0], out_code[15:8], out_data[31:16], status[33:32],
   // zero fill to 40
   output logic [39:0] rsp_tdata,
   // tuser: res_kind
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data
);

   localparam int AW = $clog2(SLOTS);
   localparam logic [5:0] LASTSLOT = 6'(SLOTS - 1);

   // state codes
   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;   // read slot at ptr
   localparam logic [3:0] S_EVAL   = 4'd3;   // data of ptr is valid
   localparam logic [3:0] S_WAIT   = 4'd4;   // relink prev to new
   localparam logic [3:0] S_DONE   = 4'd5;

   // operation phases
   localparam logic [2:0] P_EVICT  = 3'd0;
   localparam logic [2:0] P_INS    = 3'd1;
   localparam logic [2:0] P_CAN    = 3'd2;
   localparam logic [2:0] P_WRAP   = 3'd3;
   localparam logic [2:0] P_POST   = 3'd4;
   localparam logic [2:0] P_FREE   = 3'd5;   // read free slot link

   // slot and link memories
   logic [63:0] slot_mem [SLOTS];   // deadline, class, code, data
   logic [5:0]  link_mem [SLOTS];
   logic [63:0] slot_rd;
   logic [5:0]  link_rd;
   logic        sw_en, lw_en;
   logic [AW-1:0] s_ra, sw_a, lw_a;
   logic [63:0] sw_d;
   logic [5:0]  lw_d;

   always_ff @(posedge clock) begin
      if (sw_en) slot_mem[sw_a] <= sw_d;
      if (lw_en) link_mem[lw_a] <= lw_d;
      slot_rd <= slot_mem[s_ra];
      link_rd <= link_mem[s_ra];
   end

   logic [3:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  head_ff, head_in, free_ff, free_in;
   logic [31:0] last_ff, last_in;
   logic [30:0] wrap_ff, wrap_in;
   logic [5:0]  ptr_ff, ptr_in, prev_ff, prev_in, new_ff, new_in;
   logic [31:0] when_ff, when_in, now_ff, now_in;
   event_type   ev_ff, ev_in;
   logic        found_ff, found_in;
   logic [1:0]  stat_ff, stat_in;
   result_type  res_ff, res_in;
   logic        rv_ff, rv_in;

   wire         idle = (state_ff == S_IDLE);
   assign req_tready = idle;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, res_ff.status, res_ff.out_data, res_ff.out_code,
                        res_ff.out_class};
   assign rsp_tuser  = res_ff.res_kind;
   assign rsp_tlast  = res_ff.last;

   wire signed [31:0] rd_dl = slot_rd[63:32];
   event_type rd_ev;
   assign rd_ev = slot_rd[31:0];
   wire signed [32:0] wsub = {rd_dl[31], rd_dl} - {2'b00, wrap_ff};
   wire signed [31:0] wsat = (wsub < -33'sd2147483648) ? 32'sh80000000 : wsub[31:0];
   wire [31:0] req_when = {1'b0, req_tdata[30:0]} + {16'd0, req_tdata[46:31]};
   wire signed [31:0] req_when_s = req_when[31] ? 32'sh7fffffff : req_when;

   function automatic result_type post_res(input event_type e);
      result_type r;
      r = '0;
      r.out_class = e.ev_class;
      r.out_code  = e.ev_code;
      r.out_data  = e.ev_data;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; head_in = head_ff; free_in = free_ff;
      last_in = last_ff; wrap_in = wrap_ff; ptr_in = ptr_ff; prev_in = prev_ff;
      new_in = new_ff; when_in = when_ff; now_in = now_ff; ev_in = ev_ff;
      found_in = found_ff; stat_in = stat_ff; res_in = res_ff; rv_in = rv_ff;
      sw_en = 1'b0; lw_en = 1'b0; sw_a = ptr_ff[AW-1:0]; lw_a = ptr_ff[AW-1:0];
      sw_d = '0; lw_d = '0; s_ra = ptr_ff[AW-1:0];
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      if (csr_valid) wrap_in = csr_data;
      case (state_ff)
         S_INIT: begin
            // clearing pass: build the free chain
            lw_en = 1'b1;
            lw_d  = (ptr_ff == LASTSLOT) ? NIL : ptr_ff + 6'd1;
            ptr_in = ptr_ff + 6'd1;
            if (ptr_ff == LASTSLOT) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               now_in = {1'b0, req_tdata[30:0]};
               when_in = req_when_s;
               ev_in = {req_tdata[54:47], req_tdata[62:55], req_tdata[78:63]};
               found_in = 1'b0; stat_in = ST_OK;
               state_in = S_DONE;
               case (req_tuser)
                  REQ_SET: begin
                     if (free_ff == NIL) begin
                        if (head_ff != NIL) begin
                           phase_in = P_EVICT; ptr_in = head_ff; state_in = S_RD;
                           stat_in = ST_EVICT;
                        end
                     end else begin
                        phase_in = P_FREE; ptr_in = free_ff; state_in = S_RD;
                     end
                  end
                  REQ_CANCEL: begin
                     phase_in = P_CAN; ptr_in = head_ff; prev_in = NIL;
                     state_in = S_RD;
                  end
                  REQ_TICK: begin
                     last_in = {1'b0, req_tdata[30:0]};
                     ptr_in = head_ff; state_in = S_RD;
                     phase_in = ({1'b0, req_tdata[30:0]} < last_ff) ? P_WRAP : P_POST;
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            if (ptr_ff == NIL) begin
               case (phase_ff)
                  P_CAN: begin
                     if (!found_ff) stat_in = ST_NOMATCH;
                     state_in = S_DONE;
                  end
                  P_WRAP: begin
                     phase_in = P_POST; ptr_in = head_ff;
                  end
                  P_INS: begin
                     // append at tail (prev) or as head
                     lw_en = 1'b1; lw_a = new_ff[AW-1:0]; lw_d = NIL;
                     state_in = S_WAIT; phase_in = P_INS;
                  end
                  default: state_in = S_DONE;
               endcase
            end else begin
               s_ra = ptr_ff[AW-1:0];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            case (phase_ff)
               P_EVICT, P_POST: begin
                  if (phase_ff == P_POST && !($signed(now_ff) > rd_dl)) begin
                     state_in = S_DONE;
                  end else if (!rv_ff) begin
                     res_in = post_res(rd_ev); rv_in = 1'b1;
                     head_in = link_rd;
                     lw_en = 1'b1; lw_d = free_ff; free_in = ptr_ff;
                     if (phase_ff == P_EVICT) begin
                        phase_in = P_FREE; state_in = S_RD;
                     end else begin
                        ptr_in = link_rd; state_in = S_RD;
                     end
                  end
               end
               P_FREE: begin
                  // take free slot and write payload
                  free_in = link_rd; new_in = ptr_ff;
                  sw_en = 1'b1; sw_d = {when_ff, ev_ff};
                  phase_in = P_INS; prev_in = NIL; ptr_in = head_ff;
                  state_in = S_RD;
               end
               P_INS: begin
                  if ($signed(when_ff) >= rd_dl) begin
                     prev_in = ptr_ff; ptr_in = link_rd; state_in = S_RD;
                  end else begin
                     lw_en = 1'b1; lw_a = new_ff[AW-1:0]; lw_d = ptr_ff;
                     state_in = S_WAIT;
                  end
               end
               P_CAN: begin
                  state_in = S_RD; ptr_in = link_rd;
                  if (rd_ev == ev_ff) begin
                     found_in = 1'b1;
                     lw_en = 1'b1; lw_d = free_ff; free_in = ptr_ff;
                     if (prev_ff == NIL) head_in = link_rd;
                     else begin
                        // relink prev on next cycle via WAIT
                        new_in = link_rd; state_in = S_WAIT;
                     end
                  end else prev_in = ptr_ff;
               end
               P_WRAP: begin
                  sw_en = 1'b1; sw_d = {wsat, rd_ev};
                  ptr_in = link_rd; state_in = S_RD;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WAIT: begin
            lw_a = prev_ff[AW-1:0];
            if (phase_ff == P_CAN) begin
               lw_en = 1'b1; lw_d = new_ff; state_in = S_RD;
            end else begin
               if (prev_ff == NIL) head_in = new_ff;
               else begin
                  lw_en = 1'b1; lw_d = new_ff;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rv_ff) begin
               res_in = '0; res_in.res_kind = 1'b1; res_in.last = 1'b1;
               res_in.status = stat_ff; rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; ptr_ff <= '0; head_ff <= NIL; free_ff <= '0;
         last_ff <= '0; wrap_ff <= 31'd1573040; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ptr_ff <= ptr_in; head_ff <= head_in; free_ff <= free_in;
         last_ff <= last_in; wrap_ff <= wrap_in; rv_ff <= rv_in;
      end
      phase_ff <= phase_in; prev_ff <= prev_in; new_ff <= new_in;
      when_ff <= when_in; now_ff <= now_in; ev_ff <= ev_in; found_ff <= found_in;
      stat_ff <= stat_in; res_ff <= res_in;
   end

endmodule
